// ----- rtl/color_difference_median_smoothing_macros.svh -----
// Assertion macros used by the checker file of the smoothing block.
// CDMS_ASSERT is muted while reset is low; CDMS_ASSERT_ALWAYS is not.
`ifndef COLOR_DIFFERENCE_MEDIAN_SMOOTHING_MACROS_SVH
`define COLOR_DIFFERENCE_MEDIAN_SMOOTHING_MACROS_SVH

`define CDMS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`define CDMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cdms_pkg.sv -----
// ============================================================================
// cdms_pkg
// Constants, types and small compare functions of the color-difference
// median smoothing block.
// ============================================================================
`default_nettype none

package cdms_pkg;

  localparam int unsigned MaxWidth = 4096;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned PendW    = $clog2(MaxWidth + 2);
  localparam int unsigned PixW     = 16;
  localparam int unsigned DiffW    = PixW + 1;
  localparam int unsigned FwW      = 13;
  localparam int unsigned FhW      = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = CfgIdxW'(1);

  localparam logic [FwW-1:0] FwReset = FwW'(4096);
  localparam logic [FhW-1:0] FhReset = FhW'(2048);
  localparam logic [FwW-1:0] FwMin   = FwW'(3);
  localparam logic [FhW-1:0] FhMin   = FhW'(3);

  // Input operation codes.
  localparam logic OpPixel = 1'b0;
  localparam logic OpFlush = 1'b1;

  typedef logic [PixW-1:0]         sample_t;
  typedef logic signed [DiffW-1:0] diff_t;

  typedef struct packed {
    sample_t r;
    sample_t g;
    sample_t b;
  } pixel_t;

  // One line-store word holds a column of the two previous rows.
  typedef struct packed {
    pixel_t older;
    pixel_t prev;
  } line_word_t;

  typedef struct packed {
    diff_t lo;
    diff_t mid;
    diff_t hi;
  } col_sort_t;

  // Per-word control from the sequencer to the datapath.
  typedef struct packed {
    logic            step;
    logic            wr;
    logic [ColW-1:0] col;
    logic            emit;
    logic            smooth;
    logic            eof;
  } step_ctl_t;

  function automatic diff_t diff_of(sample_t c, sample_t g);
    diff_of = $signed({1'b0, c}) - $signed({1'b0, g});
  endfunction

  function automatic diff_t max2(diff_t a, diff_t b);
    max2 = (a > b) ? a : b;
  endfunction

  function automatic diff_t min2(diff_t a, diff_t b);
    min2 = (a < b) ? a : b;
  endfunction

  function automatic diff_t max3(diff_t a, diff_t b, diff_t c);
    max3 = max2(max2(a, b), c);
  endfunction

  function automatic diff_t min3(diff_t a, diff_t b, diff_t c);
    min3 = min2(min2(a, b), c);
  endfunction

  function automatic diff_t med3(diff_t a, diff_t b, diff_t c);
    med3 = max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_sort_t sort3(diff_t a, diff_t b, diff_t c);
    col_sort_t s;
    s.lo  = min3(a, b, c);
    s.mid = med3(a, b, c);
    s.hi  = max3(a, b, c);
    sort3 = s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cdms_if.sv -----
// ============================================================================
// cdms_if
// Valid/ready channels of the smoothing block: pixel input, pixel output
// and configuration write.
// ============================================================================
`default_nettype none

interface cdms_in_if;
  import cdms_pkg::*;
  logic    valid;
  logic    ready;
  logic    operation;
  sample_t red_in;
  sample_t green_in;
  sample_t blue_in;
  modport source (output valid, operation, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

interface cdms_out_if;
  import cdms_pkg::*;
  logic    valid;
  logic    ready;
  sample_t red_out;
  sample_t green_out;
  sample_t blue_out;
  logic    end_of_frame;
  modport source (output valid, red_out, green_out, blue_out, end_of_frame, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, end_of_frame, output ready);
endinterface

interface cdms_cfg_if;
  import cdms_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/cdms_ram.sv -----
// ============================================================================
// cdms_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module cdms_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/cdms_ctrl.sv -----
// ============================================================================
// cdms_ctrl
// Frame sequencer: size registers, column, row and drain counters, and the
// per-word decisions (emit, smooth, end of frame, line-store write).
// ============================================================================
`default_nettype none

module cdms_ctrl
  import cdms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                acc_i,
  input  logic                op_i,
  output step_ctl_t           ctl_o,
  output logic [ColW-1:0]     rd_addr_o
);

  logic [FwW-1:0]   fw_q, fw_d;
  logic [FhW-1:0]   fh_q, fh_d;
  logic [ColW-1:0]  col_q, col_d, col_e, col_inc, w_last;
  logic [FhW-1:0]   row_q, row_d, row_e, h_last;
  logic [PendW-1:0] pend_q, pend_d;
  logic             is_flush, pend_nz, col_last, row_last, cfg_hit, step, emit_ok;

  always_comb begin
    if (fw_q < FwMin) begin
      w_last = ColW'(2);
    end else if (32'(fw_q) > MaxWidth) begin
      w_last = ColW'(MaxWidth - 1);
    end else begin
      w_last = ColW'(fw_q - FwW'(1));
    end
    h_last = (fh_q < FhMin) ? FhW'(2) : fh_q - FhW'(1);
  end

  assign is_flush = (op_i == OpFlush);
  assign pend_nz  = (pend_q != '0);

  // A new pixel arriving while the previous frame still drains starts over.
  assign col_e    = (!is_flush && pend_nz) ? '0 : col_q;
  assign row_e    = (!is_flush && pend_nz) ? '0 : row_q;
  assign col_last = (col_e == w_last);
  assign row_last = (row_e == h_last);
  assign col_inc  = col_last ? '0 : col_e + ColW'(1);

  assign step    = acc_i && (!is_flush || pend_nz);
  assign emit_ok = is_flush ? pend_nz
                 : ((col_e == '0) ? (row_e >= FhW'(2)) : (row_e >= FhW'(1)));

  assign cfg_hit = cfg_we_i && (cfg_idx_i == CfgFrameWidth || cfg_idx_i == CfgFrameHeight);

  always_comb begin
    fw_d   = fw_q;
    fh_d   = fh_q;
    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFrameWidth:  fw_d = cfg_data_i[FwW-1:0];
        CfgFrameHeight: fh_d = cfg_data_i[FhW-1:0];
        default:        ;
      endcase
      if (cfg_hit) begin
        col_d  = '0;
        row_d  = '0;
        pend_d = '0;
      end
    end else if (acc_i) begin
      if (!is_flush) begin
        col_d  = col_inc;
        row_d  = col_last ? (row_last ? '0 : row_e + FhW'(1)) : row_e;
        pend_d = (col_last && row_last) ? PendW'(w_last) + PendW'(2) : '0;
      end else if (pend_q == PendW'(1)) begin
        pend_d = '0;
        col_d  = '0;
      end else if (pend_nz) begin
        pend_d = pend_q - PendW'(1);
        col_d  = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= FwReset;
      fh_q   <= FhReset;
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= '0;
    end else begin
      fw_q   <= fw_d;
      fh_q   <= fh_d;
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
    end
  end

  always_comb begin
    ctl_o.step   = step;
    ctl_o.wr     = acc_i && !is_flush;
    ctl_o.col    = col_e;
    ctl_o.emit   = step && emit_ok;
    ctl_o.smooth = !is_flush && (row_e >= FhW'(2)) && (col_e >= ColW'(2));
    ctl_o.eof    = is_flush && (pend_q == PendW'(1));
  end

  // The line store is read one word ahead, at the column the next item uses.
  assign rd_addr_o = col_d;

endmodule

`default_nettype wire

// ----- rtl/cdms_window.sv -----
// ============================================================================
// cdms_window
// 3x3 window held as sorted red-green and blue-green difference columns,
// plus the raw middle-row pixels that feed the output.
// ============================================================================
`default_nettype none

module cdms_window
  import cdms_pkg::*;
(
  input  logic            clk_i,
  input  logic            step_i,
  input  pixel_t          cur_i,
  input  line_word_t      line_i,
  output col_sort_t [2:0] red_cols_o,
  output col_sort_t [2:0] blue_cols_o,
  output pixel_t          center_o
);

  col_sort_t [2:0] red_q, blue_q;
  col_sort_t       red_new, blue_new;
  pixel_t          mid1_q, mid2_q;

  // Each column is sorted once as it enters and then just shifts along.
  assign red_new  = sort3(diff_of(line_i.older.r, line_i.older.g),
                          diff_of(line_i.prev.r, line_i.prev.g),
                          diff_of(cur_i.r, cur_i.g));
  assign blue_new = sort3(diff_of(line_i.older.b, line_i.older.g),
                          diff_of(line_i.prev.b, line_i.prev.g),
                          diff_of(cur_i.b, cur_i.g));

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      red_q[0]  <= red_q[1];
      red_q[1]  <= red_q[2];
      red_q[2]  <= red_new;
      blue_q[0] <= blue_q[1];
      blue_q[1] <= blue_q[2];
      blue_q[2] <= blue_new;
      mid1_q    <= mid2_q;
      mid2_q    <= line_i.prev;
    end
  end

  assign red_cols_o  = red_q;
  assign blue_cols_o = blue_q;
  assign center_o    = mid1_q;

endmodule

`default_nettype wire

// ----- rtl/cdms_median.sv -----
// ============================================================================
// cdms_median
// Median of nine differences from three sorted columns, added back to the
// center green and clamped to the sample range.
// ============================================================================
`default_nettype none

module cdms_median
  import cdms_pkg::*;
(
  input  col_sort_t [2:0] cols_i,
  input  sample_t         green_i,
  output sample_t         value_o
);

  diff_t             lo_max, mid_med, hi_min, med;
  logic [DiffW:0]    sum;

  // Median of a 3x3 set: the middle of the largest low, the middle middle
  // and the smallest high of the sorted columns.
  assign lo_max  = max3(cols_i[0].lo, cols_i[1].lo, cols_i[2].lo);
  assign mid_med = med3(cols_i[0].mid, cols_i[1].mid, cols_i[2].mid);
  assign hi_min  = min3(cols_i[0].hi, cols_i[1].hi, cols_i[2].hi);
  assign med     = med3(lo_max, mid_med, hi_min);

  assign sum = {med[DiffW-1], med} + {2'b00, green_i};

  always_comb begin
    if (sum[DiffW]) begin
      value_o = '0;
    end else if (sum[DiffW-1:PixW] != '0) begin
      value_o = '1;
    end else begin
      value_o = sum[PixW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/color_difference_median_smoothing.sv -----
// ============================================================================
// color_difference_median_smoothing
// Streaming 3x3 color-difference median filter for demosaiced RGB pixels.
//
// Pixels enter in raster order on in_i; each word carries an operation: a new
// pixel, or a flush that pushes out one result still held inside. Results
// leave on out_o one row plus one pixel behind the input, so after the last
// pixel of a frame frame_width + 1 flush words drain the tail; the final one
// is marked end_of_frame. Flushes with nothing held give no result.
// Interior pixels get red and blue replaced by the median of the window's
// color differences plus the center green; border pixels pass unchanged.
// cfg_i writes frame_width (index 0) and frame_height (index 1) and restarts
// the frame; it is always ready and holds off any input word in the same cycle.
// One word is taken every cycle unless the output stalls or a config write
// holds it off. A result is marked in the window stage, then registered with
// its medians in the output register; the line store is read at the next
// column in advance. When the receiver stalls, one result waits in the
// output register and one in the window stage before in_i drops ready.
// Reset restores the default frame size and empties the pipeline; the line
// store needs no clearing.
// ============================================================================
`default_nettype none

module color_difference_median_smoothing
  import cdms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  cdms_in_if.sink    in_i,
  cdms_out_if.source out_o,
  cdms_cfg_if.sink   cfg_i
);

  step_ctl_t                    ctl;
  logic [ColW-1:0]              rd_addr;
  logic [$bits(line_word_t)-1:0] line_raw;
  line_word_t                   line_rd;
  line_word_t                   line_wr;
  pixel_t                       cur;
  col_sort_t [2:0]              red_cols, blue_cols;
  pixel_t                       center;
  sample_t                      red_sm, blue_sm;

  logic   in_ready, acc, s1_adv;
  logic   s1_valid_q, s1_smooth_q, s1_eof_q;
  logic   out_valid_q, out_eof_q;
  pixel_t out_pix_q;

  assign cfg_i.ready = 1'b1;

  assign s1_adv   = !out_valid_q || out_o.ready;
  assign in_ready = (!s1_valid_q || s1_adv) && !cfg_i.valid;
  assign acc      = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Flush words shift a blank pixel into the window.
  always_comb begin
    if (in_i.operation == OpFlush) begin
      cur = '0;
    end else begin
      cur.r = in_i.red_in;
      cur.g = in_i.green_in;
      cur.b = in_i.blue_in;
    end
  end

  cdms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .acc_i      (acc),
    .op_i       (in_i.operation),
    .ctl_o      (ctl),
    .rd_addr_o  (rd_addr)
  );

  assign line_rd       = line_word_t'(line_raw);
  assign line_wr.older = line_rd.prev;
  assign line_wr.prev  = cur;

  cdms_ram #(
    .Width ($bits(line_word_t)),
    .Depth (MaxWidth)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ctl.wr),
    .waddr_i (ctl.col),
    .wdata_i (line_wr),
    .raddr_i (rd_addr),
    .rdata_o (line_raw)
  );

  cdms_window u_window (
    .clk_i       (clk_i),
    .step_i      (ctl.step),
    .cur_i       (cur),
    .line_i      (line_rd),
    .red_cols_o  (red_cols),
    .blue_cols_o (blue_cols),
    .center_o    (center)
  );

  cdms_median u_med_red (
    .cols_i  (red_cols),
    .green_i (center.g),
    .value_o (red_sm)
  );

  cdms_median u_med_blue (
    .cols_i  (blue_cols),
    .green_i (center.g),
    .value_o (blue_sm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_q <= ctl.emit;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_smooth_q <= ctl.smooth;
      s1_eof_q    <= ctl.eof;
    end
    if (s1_adv && s1_valid_q) begin
      out_pix_q.r <= s1_smooth_q ? red_sm : center.r;
      out_pix_q.g <= center.g;
      out_pix_q.b <= s1_smooth_q ? blue_sm : center.b;
      out_eof_q   <= s1_eof_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.red_out      = out_pix_q.r;
  assign out_o.green_out    = out_pix_q.g;
  assign out_o.blue_out     = out_pix_q.b;
  assign out_o.end_of_frame = out_eof_q;

endmodule

`default_nettype wire

// ----- rtl/cdms_checker.sv -----
// ============================================================================
// cdms_checker
// Port-level checks of the smoothing block, bound to the top level.
// ============================================================================
`default_nettype none

`include "color_difference_median_smoothing_macros.svh"

module cdms_checker
  import cdms_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input sample_t out_red_i,
  input sample_t out_green_i,
  input sample_t out_blue_i,
  input logic    out_eof_i,
  input logic    cfg_valid_i,
  input logic    cfg_ready_i
);

  `CDMS_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_i, "result valid during reset")

  `CDMS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable({out_red_i, out_green_i, out_blue_i, out_eof_i}), "stalled result changed")

  // Input may only be held off by a stalled output or a config write.
  `CDMS_ASSERT(a_in_stall_cause, clk_i, rst_ni, in_valid_i && !in_ready_i && !cfg_valid_i |-> out_valid_i && !out_ready_i, "input refused without output stall")

  `CDMS_ASSERT(a_cfg_always_taken, clk_i, rst_ni, cfg_valid_i |-> cfg_ready_i, "config write refused")

endmodule

bind color_difference_median_smoothing cdms_checker u_cdms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_red_i   (out_o.red_out),
  .out_green_i (out_o.green_out),
  .out_blue_i  (out_o.blue_out),
  .out_eof_i   (out_o.end_of_frame),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);

`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for color_difference_median_smoothing
// Drives pixel and flush words in raster order under changing frame sizes and
// idle patterns. A scoreboard predicts every output pixel from the accepted
// words and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cdms_pkg::*;

  localparam int unsigned LongHold = 300;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldWidth = 48;

  typedef struct packed {
    sample_t r;
    sample_t g;
    sample_t b;
    logic    eof;
  } out_pixel_t;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  class pixel_scoreboard;
    pixel_t      prev_row[MaxWidth];
    pixel_t      older_row[MaxWidth];
    pixel_t      win[3][3];
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned tail_left;
    out_pixel_t  awaited[$];
    int unsigned errors;
    int unsigned useful_words;

    function new();
      foreach (prev_row[i]) begin
        prev_row[i] = '0;
        older_row[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      width_reg = FwReset;
      height_reg = FhReset;
      col_pos = 0;
      row_pos = 0;
      tail_left = 0;
      errors = 0;
      useful_words = 0;
    endfunction

    function void take_config(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgFrameWidth) begin
        width_reg = data[FwW-1:0];
      end else if (idx == CfgFrameHeight) begin
        height_reg = data[FhW-1:0];
      end else begin
        return;
      end
      col_pos = 0;
      row_pos = 0;
      tail_left = 0;
    endfunction

    // Moves the window one column left and loads the new column from the two
    // stored rows and the current pixel.
    function void shift_in(int unsigned col, pixel_t cur, bit keep);
      pixel_t above2;
      pixel_t above1;
      above2 = older_row[col];
      above1 = prev_row[col];
      if (keep) begin
        older_row[col] = above1;
        prev_row[col] = cur;
      end
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = above2;
      win[1][2] = above1;
      win[2][2] = cur;
    endfunction

    function sample_t median_of_differences(bit blue);
      diff_t   d[9];
      diff_t   t;
      sample_t c;
      int      k;
      int      v;
      k = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          c = blue ? win[i][j].b : win[i][j].r;
          d[k] = $signed({1'b0, c}) - $signed({1'b0, win[i][j].g});
          k++;
        end
      end
      for (int i = 1; i < 9; i++) begin
        for (int j = i; j > 0 && d[j-1] > d[j]; j--) begin
          t = d[j];
          d[j] = d[j-1];
          d[j-1] = t;
        end
      end
      v = int'(d[4]) + int'(win[1][1].g);
      if (v < 0) return '0;
      if (v > (1 << PixW) - 1) return '1;
      return sample_t'(v);
    endfunction

    function void await_pixel(pixel_t p, logic eof);
      out_pixel_t o;
      o.r = p.r;
      o.g = p.g;
      o.b = p.b;
      o.eof = eof;
      awaited.push_back(o);
    endfunction

    function void take_word(logic op, sample_t r, sample_t g, sample_t b);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned row;
      pixel_t      cur;
      pixel_t      res;
      w = (width_reg < 3) ? 3 : ((width_reg > MaxWidth) ? MaxWidth : width_reg);
      h = (height_reg < 3) ? 3 : height_reg;
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      col = col_pos;
      row = row_pos;

      if (op == OpFlush) begin
        if (tail_left == 0) return;
        useful_words++;
        if (tail_left == 1) begin
          await_pixel(win[1][2], 1'b1);
          tail_left = 0;
          col_pos = 0;
          return;
        end
        if (col == 0) begin
          await_pixel(win[1][2], 1'b0);
          shift_in(0, '0, 1'b0);
        end else begin
          shift_in(col, '0, 1'b0);
          await_pixel(win[1][1], 1'b0);
        end
        tail_left--;
        col++;
        col_pos = (col >= w) ? 0 : col;
        return;
      end

      useful_words++;
      // A pixel arriving while the tail is still held starts a new frame.
      if (tail_left != 0) begin
        tail_left = 0;
        col = 0;
        row = 0;
      end
      cur.r = r;
      cur.g = g;
      cur.b = b;
      if (col == 0) begin
        if (row >= 2) await_pixel(win[1][2], 1'b0);
        shift_in(col, cur, 1'b1);
      end else begin
        shift_in(col, cur, 1'b1);
        if (row >= 1) begin
          res = win[1][1];
          if (row >= 2 && col >= 2) begin
            res.r = median_of_differences(1'b0);
            res.b = median_of_differences(1'b1);
          end
          await_pixel(res, 1'b0);
        end
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) begin
          row = 0;
          tail_left = w + 1;
        end
      end
      col_pos = col;
      row_pos = row;
    endfunction

    function void check_pixel(out_pixel_t got);
      out_pixel_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected output word: r=%h g=%h b=%h eof=%b",
                   got.r, got.g, got.b, got.eof);
        end
        return;
      end
      want = awaited.pop_front();
      if (got.r !== want.r || got.g !== want.g || got.b !== want.b ||
          got.eof !== want.eof) begin
        errors++;
        if (errors <= 10) begin
          $display("output word differs: expected r=%h g=%h b=%h eof=%b, got r=%h g=%h b=%h eof=%b",
                   want.r, want.g, want.b, want.eof, got.r, got.g, got.b, got.eof);
        end
      end
    endfunction

    function void report_leftover();
      if (awaited.size() != 0) begin
        errors++;
        $display("%0d output words never arrived", awaited.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  cdms_in_if  in_ch();
  cdms_out_if out_ch();
  cdms_cfg_if cfg_ch();

  color_difference_median_smoothing i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  pixel_scoreboard sb = new();

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_off_req = 1'b0;

  always #6 clk = ~clk;

  always @(posedge clk) begin : watch
    out_pixel_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.take_word(in_ch.operation, in_ch.red_in, in_ch.green_in, in_ch.blue_in);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.r = out_ch.red_out;
        got.g = out_ch.green_out;
        got.b = out_ch.blue_out;
        got.eof = out_ch.end_of_frame;
        sb.check_pixel(got);
      end
      if (cfg_ch.valid && cfg_ch.ready) sb.take_config(cfg_ch.index, cfg_ch.data);
    end
  end

  initial begin : receiver
    int unsigned held;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        // Keep ready low long enough for the block to back up into its input.
        out_ch.ready <= 1'b0;
        for (held = 0; held < LongHold; held++) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("color_difference_median_smoothing: mismatch");
    $finish;
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Leaves valid high after the word is taken; the next call or settle()
  // decides what happens in the following cycle.
  task automatic send_word(logic op, sample_t r, sample_t g, sample_t b);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.red_in <= r;
    in_ch.green_in <= g;
    in_ch.blue_in <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_pixel();
    send_word(OpPixel, pick_sample(), pick_sample(), pick_sample());
  endtask

  task automatic send_flush();
    send_word(OpFlush, sample_t'($urandom), sample_t'($urandom), sample_t'($urandom));
  endtask

  task automatic send_frame(int unsigned w, int unsigned rows, int unsigned flushes);
    for (int unsigned k = 0; k < w * rows; k++) begin
      // A stray flush drains a leftover tail word if one is held, else it is
      // dropped.
      if ($urandom_range(99) < 4) send_flush();
      send_pixel();
    end
    for (int unsigned k = 0; k < flushes; k++) send_flush();
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin : stimulus
    idle_mode_e          mode;
    logic [CfgDataW-1:0] w_data;
    logic [CfgDataW-1:0] h_data;
    logic [FwW-1:0]      w_reg;
    logic [FhW-1:0]      h_reg;
    int unsigned         w;
    int unsigned         pick;
    int unsigned         frames;
    int unsigned         tail;
    int unsigned         phase;

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OpPixel;
    in_ch.red_in <= '0;
    in_ch.green_in <= '0;
    in_ch.blue_in <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CfgFrameWidth;
    cfg_ch.data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest frame through out-of-range writes. The first frame drives the
    // center median below zero, the second above full scale.
    write_reg(CfgFrameWidth, CfgDataW'(0));
    write_reg(CfgFrameHeight, CfgDataW'(1));
    for (int k = 0; k < 9; k++) begin
      if (k == 4) send_word(OpPixel, 16'h1234, 16'h0000, 16'h4321);
      else send_word(OpPixel, 16'h0000, 16'hFFFF, 16'h0000);
    end
    repeat (5) send_flush();
    for (int k = 0; k < 9; k++) begin
      if (k == 4) send_word(OpPixel, 16'h0000, 16'hFFFF, 16'h0007);
      else send_word(OpPixel, 16'hFFFF, 16'h0000, 16'hFFFF);
    end
    send_flush();
    send_pixel();
    settle();

    w_reg = FwMin;
    h_reg = FhMin;
    phase = 0;
    while (sb.useful_words < 800) begin
      mode = idle_mode_e'(phase % 4);
      case (mode)
        IdleNone: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        IdleSender: begin
          gap_pct = 59;
          stall_pct = 0;
        end
        IdleReceiver: begin
          gap_pct = 0;
          stall_pct = 59;
        end
        default: begin
          gap_pct = 16;
          stall_pct = 16;
        end
      endcase

      case ($urandom_range(19))
        0, 1: w_data = CfgDataW'($urandom_range(2));
        2: w_data = 16'hE000 | CfgDataW'($urandom_range(3, 8));
        default: w_data = CfgDataW'($urandom_range(3, 10));
      endcase
      case ($urandom_range(19))
        0, 1: h_data = CfgDataW'($urandom_range(2));
        2: h_data = 16'hFFFF;
        default: h_data = CfgDataW'($urandom_range(3, 6));
      endcase
      pick = $urandom_range(3);
      if (pick != 3) begin
        write_reg(CfgFrameWidth, w_data);
        w_reg = w_data[FwW-1:0];
      end
      if (pick != 2) begin
        write_reg(CfgFrameHeight, h_data);
        h_reg = h_data[FhW-1:0];
      end
      w = (w_reg < 3) ? 3 : ((w_reg > MaxWidth) ? MaxWidth : w_reg);

      if (h_reg == 16'hFFFF) begin
        // Frame far too tall to finish; the next register write cuts it off.
        send_frame(w, 3, 0);
      end else begin
        frames = $urandom_range(1, 3);
        for (int unsigned f = 0; f < frames; f++) begin
          case ($urandom_range(19))
            0, 1, 2: tail = $urandom_range(w);
            3, 4, 5: tail = w + 1 + $urandom_range(1, 3);
            default: tail = w + 1;
          endcase
          send_frame(w, (h_reg < 3) ? 3 : h_reg, tail);
        end
      end
      settle();
      phase++;
    end

    // Wider frame, with the receiver holding off once while rows stream in.
    gap_pct = 0;
    stall_pct = 0;
    write_reg(CfgFrameWidth, CfgDataW'(HoldWidth));
    write_reg(CfgFrameHeight, CfgDataW'(4));
    for (int unsigned k = 0; k < 4 * HoldWidth; k++) begin
      if (k == HoldWidth + 8) hold_off_req = 1'b1;
      send_pixel();
    end
    stall_pct = 16;
    repeat (HoldWidth + 1) send_flush();
    settle();

    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("color_difference_median_smoothing: match");
    end else begin
      $display("color_difference_median_smoothing: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cdms_pkg.sv
rtl/cdms_if.sv
rtl/cdms_ram.sv
rtl/cdms_ctrl.sv
rtl/cdms_window.sv
rtl/cdms_median.sv
rtl/color_difference_median_smoothing.sv
rtl/cdms_checker.sv
test/testbench.sv
